/* design/flvmd_pkg.sv */
// shared types and constants for the flv metadata duration patcher
package flvmd_pkg;

    localparam int unsigned MsWidth  = 40;
    localparam int unsigned DblWidth = 64;

    typedef enum logic [11:0] {
        PH_PREFIX  = 12'b0000_0000_0001,
        PH_ARRTYPE = 12'b0000_0000_0010,
        PH_COUNT   = 12'b0000_0000_0100,
        PH_KLEN_HI = 12'b0000_0000_1000,
        PH_KLEN_LO = 12'b0000_0001_0000,
        PH_KEY     = 12'b0000_0010_0000,
        PH_VTYPE   = 12'b0000_0100_0000,
        PH_SLEN_HI = 12'b0000_1000_0000,
        PH_SLEN_LO = 12'b0001_0000_0000,
        PH_SKIP    = 12'b0010_0000_0000,
        PH_REWRITE = 12'b0100_0000_0000,
        PH_STOP    = 12'b1000_0000_0000
    } t_phase;

    localparam logic [7:0] AmfNumber = 8'h00;
    localparam logic [7:0] AmfBool   = 8'h01;
    localparam logic [7:0] AmfString = 8'h02;
    localparam logic [7:0] AmfEcma   = 8'h08;

    typedef struct packed {
        logic       busy;
        logic       done;
    } t_conv_status;

    function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
        logic [7:0] v;
        begin
            unique case (idx)
                4'd0:  v = 8'h02;
                4'd1:  v = 8'h00;
                4'd2:  v = 8'h0a;
                4'd3:  v = 8'h6f;
                4'd4:  v = 8'h6e;
                4'd5:  v = 8'h4d;
                4'd6:  v = 8'h65;
                4'd7:  v = 8'h74;
                4'd8:  v = 8'h61;
                4'd9:  v = 8'h44;
                4'd10: v = 8'h61;
                4'd11: v = 8'h74;
                4'd12: v = 8'h61;
                default: v = 8'h00;
            endcase
            return v;
        end
    endfunction

    function automatic logic [7:0] key_byte(input logic [2:0] idx);
        logic [7:0] v;
        begin
            unique case (idx)
                3'd0: v = 8'h64;
                3'd1: v = 8'h75;
                3'd2: v = 8'h72;
                3'd3: v = 8'h61;
                3'd4: v = 8'h74;
                3'd5: v = 8'h69;
                3'd6: v = 8'h6f;
                3'd7: v = 8'h6e;
                default: v = 8'h00;
            endcase
            return v;
        end
    endfunction

endpackage

/* design/flvmd_conv.sv */
// conversion of milliseconds to seconds as binary64 by reciprocal multiplication
module flvmd_conv
    import flvmd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MsWidth-1:0]  i_ms,
    output logic [DblWidth-1:0] o_double,
    output t_conv_status        o_status
);

    // ms/1000 = (m * 2^22 / 125) * 2^-(25+lz) with m the normalized ms value
    // quotient by 125 from m * floor(2^64/125) >> 42, off by at most one,
    // then fixed up from the low remainder bits
    localparam logic [57:0] Recip = 58'(64'hFFFF_FFFF_FFFF_FFFF / 64'd125);

    typedef enum logic [4:0] {
        CV_IDLE  = 5'b00001,
        CV_NORM  = 5'b00010,
        CV_MUL   = 5'b00100,
        CV_FIX   = 5'b01000,
        CV_PACK  = 5'b10000
    } t_cv;

    t_cv                 r_st, n_st;
    logic [MsWidth-1:0]  r_ms, n_ms;
    logic [MsWidth-1:0]  r_m, n_m;
    logic [5:0]          r_lz, n_lz;
    logic [97:0]         r_acc, n_acc;
    logic [1:0]          r_step, n_step;
    logic [55:0]         r_q, n_q;
    logic                r_stk, n_stk;
    logic [DblWidth-1:0] r_dbl, n_dbl;

    logic [5:0]  w_lz;
    logic [19:0] w_ma;
    logic [28:0] w_ra;
    logic [6:0]  w_sh;
    logic [48:0] w_pp;
    logic [55:0] w_qa;
    logic [7:0]  w_r8;
    logic [7:0]  w_rem;
    logic        w_top;
    logic [52:0] w_mant;
    logic        w_g, w_s, w_up;
    logic [53:0] w_mr;
    logic [10:0] w_e;
    logic [10:0] w_exp;

    always_comb begin
        // leading zeros of the latched ms value
        w_lz = '0;
        for (int i = 0; i < MsWidth; i++) begin
            if (r_ms[i]) begin
                w_lz = 6'(MsWidth - 1 - i);
            end
        end
        // one 20x29 partial product per cycle
        unique case (r_step)
            2'd0: begin
                w_ma = r_m[19:0];
                w_ra = Recip[28:0];
                w_sh = 7'd0;
            end
            2'd1: begin
                w_ma = r_m[19:0];
                w_ra = Recip[57:29];
                w_sh = 7'd29;
            end
            2'd2: begin
                w_ma = r_m[39:20];
                w_ra = Recip[28:0];
                w_sh = 7'd20;
            end
            2'd3: begin
                w_ma = r_m[39:20];
                w_ra = Recip[57:29];
                w_sh = 7'd49;
            end
        endcase
        w_pp  = 49'(w_ma) * 49'(w_ra);
        w_qa  = r_acc[97:42];
        // true remainder is below 250, so its low byte is enough
        w_r8  = 8'(8'd0 - w_qa[7:0] * 8'd125);
        w_rem = (w_r8 >= 8'd125) ? w_r8 - 8'd125 : w_r8;
        // quotient has its top bit at 55 or 54
        w_top  = r_q[55];
        w_mant = w_top ? r_q[55:3] : r_q[54:2];
        w_g    = w_top ? r_q[2] : r_q[1];
        w_s    = (w_top ? (r_q[1] | r_q[0]) : r_q[0]) | r_stk;
        w_up   = w_g & (w_s | w_mant[0]);
        w_mr   = {1'b0, w_mant} + {53'd0, w_up};
        w_e    = (w_top ? 11'd1053 : 11'd1052) - {5'd0, r_lz};
        w_exp  = w_mr[53] ? w_e + 11'd1 : w_e;
    end

    always_comb begin
        n_st   = r_st;
        n_ms   = r_ms;
        n_m    = r_m;
        n_lz   = r_lz;
        n_acc  = r_acc;
        n_step = r_step;
        n_q    = r_q;
        n_stk  = r_stk;
        n_dbl  = r_dbl;
        unique case (r_st)
            CV_IDLE: begin
            end
            CV_NORM: begin
                n_m    = r_ms << w_lz;
                n_lz   = w_lz;
                n_acc  = '0;
                n_step = '0;
                n_st   = CV_MUL;
            end
            CV_MUL: begin
                n_acc  = r_acc + ({49'd0, w_pp} << w_sh);
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_st = CV_FIX;
                end
            end
            CV_FIX: begin
                n_q   = (w_r8 >= 8'd125) ? w_qa + 56'd1 : w_qa;
                n_stk = (w_rem != 8'd0);
                n_st  = CV_PACK;
            end
            CV_PACK: begin
                n_dbl = {1'b0, w_exp, w_mr[53] ? w_mr[52:1] : w_mr[51:0]};
                n_st  = CV_IDLE;
            end
            default: n_st = CV_IDLE;
        endcase
        if (i_start) begin
            n_ms = i_ms;
            if (i_ms == '0) begin
                n_dbl = '0;
                n_st  = CV_IDLE;
            end else begin
                n_st = CV_NORM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= CV_IDLE;
            r_dbl <= '0;
        end else begin
            r_st  <= n_st;
            r_dbl <= n_dbl;
        end
        r_ms   <= n_ms;
        r_m    <= n_m;
        r_lz   <= n_lz;
        r_acc  <= n_acc;
        r_step <= n_step;
        r_q    <= n_q;
        r_stk  <= n_stk;
    end

    assign o_double        = r_dbl;
    assign o_status.busy   = (r_st != CV_IDLE);
    assign o_status.done   = (r_st == CV_PACK);

endmodule

/* design/flvmd_parse.sv */
// amf0 parser and byte rewrite stage
module flvmd_parse
    import flvmd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  logic [DblWidth-1:0] i_double,
    output logic [7:0]          o_byte,
    output logic                o_rw
);

    t_phase      r_ph, n_ph;
    logic [15:0] r_cnt, n_cnt;
    logic [15:0] r_klen, n_klen;
    logic        r_km, n_km;
    logic [15:0] r_skip, n_skip;
    logic [15:0] w_inc;
    logic [15:0] w_len;

    always_comb begin
        n_ph   = r_ph;
        n_cnt  = r_cnt;
        n_klen = r_klen;
        n_km   = r_km;
        n_skip = r_skip;
        o_byte = i_byte;
        o_rw   = 1'b0;
        w_inc  = r_cnt + 16'd1;
        w_len  = {r_klen[15:8], i_byte};
        unique case (r_ph)
            PH_PREFIX: begin
                if (r_cnt >= 16'd13 || i_byte != hdr_byte(r_cnt[3:0])) begin
                    n_ph = PH_STOP;
                end else if (w_inc == 16'd13) begin
                    n_cnt = '0;
                    n_ph  = PH_ARRTYPE;
                end else begin
                    n_cnt = w_inc;
                end
            end
            PH_ARRTYPE: begin
                n_cnt = '0;
                n_ph  = (i_byte == AmfEcma) ? PH_COUNT : PH_STOP;
            end
            PH_COUNT: begin
                n_cnt = w_inc;
                if (w_inc >= 16'd4) begin
                    n_ph = PH_KLEN_HI;
                end
            end
            PH_KLEN_HI: begin
                n_klen = {i_byte, 8'd0};
                n_ph   = PH_KLEN_LO;
            end
            PH_KLEN_LO: begin
                n_klen = w_len;
                n_km   = (w_len == 16'd8);
                n_cnt  = '0;
                n_ph   = (w_len != '0) ? PH_KEY : PH_VTYPE;
            end
            PH_KEY: begin
                if (r_cnt < 16'd8 && i_byte != key_byte(r_cnt[2:0])) begin
                    n_km = 1'b0;
                end
                n_cnt = w_inc;
                if (w_inc == r_klen) begin
                    n_ph = PH_VTYPE;
                end
            end
            PH_VTYPE: begin
                priority if (i_byte == AmfNumber) begin
                    if (r_km) begin
                        n_cnt = '0;
                        n_ph  = PH_REWRITE;
                    end else begin
                        n_skip = 16'd8;
                        n_ph   = PH_SKIP;
                    end
                end else if (i_byte == AmfBool) begin
                    n_skip = 16'd1;
                    n_ph   = PH_SKIP;
                end else if (i_byte == AmfString) begin
                    n_ph = PH_SLEN_HI;
                end else begin
                    n_ph = PH_STOP;
                end
            end
            PH_SLEN_HI: begin
                n_skip = {i_byte, 8'd0};
                n_ph   = PH_SLEN_LO;
            end
            PH_SLEN_LO: begin
                n_skip = {r_skip[15:8], i_byte};
                n_ph   = ({r_skip[15:8], i_byte} != '0) ? PH_SKIP : PH_KLEN_HI;
            end
            PH_SKIP: begin
                n_skip = (r_skip != '0) ? r_skip - 16'd1 : r_skip;
                if (r_skip <= 16'd1) begin
                    n_ph = PH_KLEN_HI;
                end
            end
            PH_REWRITE: begin
                o_byte = 8'(i_double >> (6'd56 - {r_cnt[2:0], 3'd0}));
                o_rw   = 1'b1;
                n_cnt  = w_inc;
                if (w_inc >= 16'd8) begin
                    n_ph = PH_STOP;
                end
            end
            PH_STOP: n_ph = PH_STOP;
            default: n_ph = PH_STOP;
        endcase
        if (i_last) begin
            n_ph   = PH_PREFIX;
            n_cnt  = '0;
            n_klen = '0;
            n_km   = 1'b0;
            n_skip = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_PREFIX;
            r_cnt  <= '0;
            r_klen <= '0;
            r_km   <= 1'b0;
            r_skip <= '0;
        end else if (i_take) begin
            r_ph   <= n_ph;
            r_cnt  <= n_cnt;
            r_klen <= n_klen;
            r_km   <= n_km;
            r_skip <= n_skip;
        end
    end

endmodule

/* design/flv_metadata_duration_patcher.sv */
// top level of the flv metadata duration patcher
// Passes the payload bytes of one FLV script-data tag, one transaction per
// cycle, and replaces the eight bytes of the onMetaData "duration" number
// with duration_ms / 1000 as a big-endian binary64. Each input transaction
// gives exactly one output transaction; an output register plus one skid
// entry lets input flow while the output is stalled, and apart from the
// conversion the input stalls only once the skid entry is full. After a
// nonzero write of duration_ms the seconds value is computed by a
// reciprocal multiplier, during which the input is stalled; a write of
// zero takes effect at once.
module flv_metadata_duration_patcher
    import flvmd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [MsWidth-1:0] i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_out_last,
    output logic               o_rewritten
);

    logic [DblWidth-1:0] w_double;
    t_conv_status        w_cst;
    logic                w_take;
    logic [7:0]          w_byte;
    logic                w_rw;

    // output register plus skid entry
    logic       r_ov, r_sv;
    logic [9:0] r_od, r_sd;

    flvmd_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cfg_we),
        .i_ms     (i_cfg_wdata),
        .o_double (w_double),
        .o_status (w_cst)
    );

    // hold input while the seconds value is being computed or the skid entry is full
    assign o_stall = r_sv | w_cst.busy;
    assign w_take  = i_valid && !o_stall;

    flvmd_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_byte   (i_data_byte),
        .i_last   (i_last_byte),
        .i_double (w_double),
        .o_byte   (w_byte),
        .o_rw     (w_rw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (!r_ov || !i_stall) begin
                if (r_sv) begin
                    r_ov <= 1'b1;
                    r_sv <= 1'b0;
                end else begin
                    r_ov <= w_take;
                end
            end else if (w_take) begin
                r_sv <= 1'b1;
            end
        end
        if (!r_ov || !i_stall) begin
            r_od <= r_sv ? r_sd : {w_byte, i_last_byte, w_rw};
        end
        if (w_take && r_ov && i_stall) begin
            r_sd <= {w_byte, i_last_byte, w_rw};
        end
    end

    assign o_valid     = r_ov;
    assign o_out_byte  = r_od[9:2];
    assign o_out_last  = r_od[1];
    assign o_rewritten = r_od[0];

`ifndef SYNTHESIS
    // skid entry only fills behind a held output
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov) else $error("skid full with empty output");
    // the output is valid in the cycle after a byte is accepted
    a_take_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_ov) else $error("accepted byte lost");
    // converter done only while busy
    a_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cst.done |-> w_cst.busy) else $error("converter status broken");
`endif

endmodule

/* tb/sv/tb_flv_metadata_duration_patcher.sv */
// testbench for the flv metadata duration patcher: random and directed tags against a predictor
`timescale 1ns / 1ps

module tb_flv_metadata_duration_patcher;
    import flvmd_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       rw;
    } t_byte_out;

    class duration_scoreboard;
        t_phase          phase;
        logic [15:0]     cnt;
        logic [15:0]     key_len;
        logic            key_ok;
        logic [15:0]     skip_len;
        logic [63:0]     dur_bits;
        t_byte_out       pending[$];
        int              errors;

        function new();
            dur_bits = '0;
            errors   = 0;
            clear();
        endfunction

        function void clear();
            phase    = PH_PREFIX;
            cnt      = '0;
            key_len  = '0;
            key_ok   = 1'b0;
            skip_len = '0;
        endfunction

        function void set_duration(logic [MsWidth-1:0] ms);
            real secs;
            secs = real'(ms) / 1000.0;
            dur_bits = $realtobits(secs);
        endfunction

        function logic [7:0] hdr_at(int k);
            logic [7:0] h[13];
            h = '{8'h02, 8'h00, 8'h0a, "o", "n", "M", "e", "t", "a", "D", "a", "t", "a"};
            return h[k];
        endfunction

        function logic [7:0] key_at(int k);
            logic [7:0] s[8];
            s = '{"d", "u", "r", "a", "t", "i", "o", "n"};
            return s[k];
        endfunction

        // advance the parser by one input transaction and queue the expected output
        function void note_input(logic [7:0] b, logic last);
            t_byte_out e;
            e.data = b;
            e.last = last;
            e.rw   = 1'b0;
            case (phase)
                PH_PREFIX: begin
                    if (cnt >= 13 || b != hdr_at(cnt)) begin
                        phase = PH_STOP;
                    end else begin
                        cnt++;
                        if (cnt == 13) begin
                            cnt   = 0;
                            phase = PH_ARRTYPE;
                        end
                    end
                end
                PH_ARRTYPE: begin
                    cnt   = 0;
                    phase = (b == AmfEcma) ? PH_COUNT : PH_STOP;
                end
                PH_COUNT: begin
                    cnt++;
                    if (cnt >= 4) phase = PH_KLEN_HI;
                end
                PH_KLEN_HI: begin
                    key_len = {b, 8'h00};
                    phase   = PH_KLEN_LO;
                end
                PH_KLEN_LO: begin
                    key_len = key_len | b;
                    key_ok  = (key_len == 8);
                    cnt     = 0;
                    phase   = (key_len != 0) ? PH_KEY : PH_VTYPE;
                end
                PH_KEY: begin
                    if (cnt < 8 && b != key_at(cnt)) key_ok = 1'b0;
                    cnt++;
                    if (cnt == key_len) phase = PH_VTYPE;
                end
                PH_VTYPE: begin
                    if (b == AmfNumber) begin
                        if (key_ok) begin
                            cnt   = 0;
                            phase = PH_REWRITE;
                        end else begin
                            skip_len = 8;
                            phase    = PH_SKIP;
                        end
                    end else if (b == AmfBool) begin
                        skip_len = 1;
                        phase    = PH_SKIP;
                    end else if (b == AmfString) begin
                        phase = PH_SLEN_HI;
                    end else begin
                        phase = PH_STOP;
                    end
                end
                PH_SLEN_HI: begin
                    skip_len = {b, 8'h00};
                    phase    = PH_SLEN_LO;
                end
                PH_SLEN_LO: begin
                    skip_len = skip_len | b;
                    phase    = (skip_len != 0) ? PH_SKIP : PH_KLEN_HI;
                end
                PH_SKIP: begin
                    if (skip_len != 0) skip_len--;
                    if (skip_len == 0) phase = PH_KLEN_HI;
                end
                PH_REWRITE: begin
                    if (cnt < 8) begin
                        e.data = dur_bits[63 - 8*cnt -: 8];
                        e.rw   = 1'b1;
                    end
                    cnt++;
                    if (cnt >= 8) phase = PH_STOP;
                end
                default: phase = PH_STOP;
            endcase
            pending.push_back(e);
            if (last) clear();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [7:0] b, logic last, logic rw);
            t_byte_out e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected output byte %h", b));
                return;
            end
            e = pending.pop_front();
            if (b !== e.data) report($sformatf("out_byte %h, expected %h", b, e.data));
            if (last !== e.last) report($sformatf("out_last %b, expected %b", last, e.last));
            if (rw !== e.rw) report($sformatf("rewritten %b, expected %b", rw, e.rw));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [MsWidth-1:0] i_cfg_wdata = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_data_byte = '0;
    logic               i_last_byte = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [7:0]         o_out_byte;
    logic               o_out_last;
    logic               o_rewritten;

    duration_scoreboard sb = new();
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_req = 0;
    int   cycles = 0;
    logic [7:0] tag_q[$];

    flv_metadata_duration_patcher DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_data_byte(i_data_byte), .i_last_byte(i_last_byte),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_byte(o_out_byte), .o_out_last(o_out_last), .o_rewritten(o_rewritten)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 600000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_out_byte, o_out_last, o_rewritten);
    end

    // receiver: random stall, plus one long hold-off on request
    initial begin
        int hold;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                i_stall  = 1'b1;
                for (hold = 0; hold < 300; hold++) @(negedge i_clk);
            end
            i_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_data_byte = b;
        i_last_byte = last;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(b, last);
        @(negedge i_clk);
    endtask

    task automatic send_tag();
        foreach (tag_q[k]) send_byte(tag_q[k], k == tag_q.size() - 1);
        i_valid = 1'b0;
        tag_q.delete();
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_duration(logic [MsWidth-1:0] ms);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = ms;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_duration(ms);
        // converter runs after the write
        repeat (300) @(negedge i_clk);
    endtask

    task automatic put_header(bit ecma);
        string name;
        name = "onMetaData";
        tag_q.push_back(8'h02); tag_q.push_back(8'h00); tag_q.push_back(8'h0a);
        foreach (name[k]) tag_q.push_back(name[k]);
        tag_q.push_back(ecma ? AmfEcma : 8'h03);
        repeat (4) tag_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic put_key(string s);
        tag_q.push_back(8'(s.len() >> 8));
        tag_q.push_back(8'(s.len()));
        foreach (s[k]) tag_q.push_back(s[k]);
    endtask

    task automatic put_number();
        tag_q.push_back(AmfNumber);
        repeat (8) tag_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic put_string(int n);
        tag_q.push_back(AmfString);
        tag_q.push_back(8'(n >> 8));
        tag_q.push_back(8'(n));
        repeat (n) tag_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic put_random_pair();
        string key;
        int    r;
        r = $urandom_range(9);
        if (r < 4) key = "duration";
        else if (r == 4) key = "duratiom";
        else if (r == 5) key = "durationx";
        else if (r == 6) key = "";
        else begin
            key = "";
            repeat ($urandom_range(1, 10)) key = {key, string'(byte'($urandom_range(255)))};
        end
        put_key(key);
        r = $urandom_range(19);
        if (r < 10) put_number();
        else if (r < 13) begin
            tag_q.push_back(AmfBool);
            tag_q.push_back(8'($urandom_range(255)));
        end else if (r < 18) put_string($urandom_range(6));
        else tag_q.push_back(8'($urandom_range(3, 255)));
    endtask

    task automatic random_tag();
        int r;
        int cut;
        r = $urandom_range(99);
        if (r < 80) begin
            put_header($urandom_range(19) != 0);
            repeat ($urandom_range(0, 4)) put_random_pair();
            if ($urandom_range(6) == 0 && tag_q.size() > 1) begin
                cut = $urandom_range(1, tag_q.size() - 1);
                while (tag_q.size() > cut) void'(tag_q.pop_back());
            end
        end else if (r < 90) begin
            put_header(1'b1);
            put_random_pair();
            tag_q[$urandom_range(12)] ^= 8'(1 << $urandom_range(7));
        end else begin
            repeat ($urandom_range(1, 20)) tag_q.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic directed();
        // duration number right after the count
        put_header(1'b1); put_key("duration"); put_number(); put_key("x"); put_number();
        send_tag();
        // rewrite happens once per tag
        put_header(1'b1); put_key("duration"); put_number(); put_key("duration"); put_number();
        send_tag();
        // duration with boolean and string values, then a number one
        put_header(1'b1); put_key("duration"); tag_q.push_back(AmfBool); tag_q.push_back(8'h01);
        put_key("duration"); put_string(3); put_key(""); put_string(0);
        put_key("duration"); put_number();
        send_tag();
        // rewrite cut off by the tag end
        put_header(1'b1); put_key("duration"); tag_q.push_back(AmfNumber);
        repeat (3) tag_q.push_back(8'hff);
        send_tag();
        // wrong array type, bad prefix, unknown value type
        put_header(1'b0); put_key("duration"); put_number(); send_tag();
        put_header(1'b1); tag_q[5] = 8'h00; put_key("duration"); put_number(); send_tag();
        put_header(1'b1); put_key("abc"); tag_q.push_back(8'h0b); put_key("duration");
        put_number(); send_tag();
        // long string length cut off, then single byte tags
        put_header(1'b1); put_key("s"); tag_q.push_back(AmfString);
        tag_q.push_back(8'hff); tag_q.push_back(8'hff); tag_q.push_back(8'h00);
        send_tag();
        tag_q.push_back(8'hff); send_tag();
        tag_q.push_back(8'h02); send_tag();
    endtask

    initial begin
        int n;
        int mode;
        logic [MsWidth-1:0] settings[4];
        settings = '{40'd1, 40'hff_ffff_ffff, 40'd0, 40'd3_723_456};
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        write_duration(40'd0);
        directed();
        write_duration(40'hff_ffff_ffff);
        directed();
        n = 0;
        for (mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 85 : 0;
            recv_idle_pct = (mode == 0) ? 85 : (mode == 1) ? 26 : 0;
            write_duration((mode == 2) ? {$urandom(), 8'($urandom())} : settings[mode]);
            if (mode == 2) hold_req = 1;
            while (n < 150 * (mode + 1)) begin
                random_tag();
                n += tag_q.size();
                send_tag();
            end
        end
        write_duration(settings[3]);
        repeat (5) begin
            random_tag();
            send_tag();
        end
        drain();
        repeat (20) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
